// ----- hw/rtl/udpck_pkg.sv -----
`default_nettype none

package udpck_pkg;

   localparam int unsigned POS_W = 17;

   localparam logic [POS_W-1:0] IP_START    = POS_W'(14);
   localparam logic [POS_W-1:0] IP_CHECK_HI = POS_W'(24);
   localparam logic [POS_W-1:0] IP_CHECK_LO = POS_W'(25);
   localparam logic [POS_W-1:0] PROTO_POS   = POS_W'(23);
   localparam logic [POS_W-1:0] ADDR_FIRST  = POS_W'(26);
   localparam logic [POS_W-1:0] ADDR_LAST   = POS_W'(33);
   localparam logic [POS_W-1:0] UDP_START   = POS_W'(34);
   localparam logic [POS_W-1:0] ULEN_HI_POS = POS_W'(38);
   localparam logic [POS_W-1:0] ULEN_LO_POS = POS_W'(39);
   localparam logic [POS_W-1:0] UDP_CHK_HI  = POS_W'(40);
   localparam logic [POS_W-1:0] UDP_CHK_LO  = POS_W'(41);
   localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};

   localparam logic [15:0] ALL_ONES = 16'hFFFF;

   typedef struct packed {
      logic        short_frame;
      logic [15:0] udp_checksum;
      logic [15:0] ip_checksum;
   } result_type;

   // fold a sum of up to eight 16-bit words back to 16 bits, end-around carry
   function automatic logic [15:0] oc_fold(input logic [18:0] total);
      logic [16:0] s1;
      logic [16:0] s2;
      s1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
      s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
      return s2[15:0];
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/udp_ipv4_checksum_engine_top.sv -----
`default_nettype none

// Streaming IPv4 header and UDP checksum engine. Frame bytes enter one per
// transaction on req_ (Ethernet header first, req_tlast on the final byte);
// the IPv4 header is expected at byte 14 and the UDP header at byte 34. A byte
// is accepted in every cycle while fewer than two results wait on rsp_: each
// byte is folded into the running sums in the same cycle it is taken, so the
// rate is one byte per clock. On the final byte the result is written into a
// two-entry output queue and leaves on rsp_ from there, so a stalled result does
// not hold the byte stream for the next frame; req_tready drops only while both
// queue entries are full.
// rsp_tuser flags a frame that ended before the IPv4 header, the UDP length
// field or the UDP length was covered; its UDP checksum is then zero.
module udp_ipv4_checksum_engine_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // last_byte
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [15:0] ip_checksum, [31:16] udp_checksum
   output      logic        rsp_tuser    // short_frame
);

   localparam int unsigned PW = udpck_pkg::POS_W;

   logic [PW-1:0] pos_ff, pos_in;
   logic [3:0]    hwords_ff, hwords_in;
   logic [15:0]   ulen_ff, ulen_in;
   logic [15:0]   ip_sum_ff, ip_sum_in;
   logic [15:0]   udp_sum_ff, udp_sum_in;
   logic [7:0]    held_ff, held_in;
   logic [7:0]    head_ff [4];

   logic          accept;
   logic [7:0]    b;
   logic [15:0]   placed;
   logic [5:0]    hlen;
   logic [6:0]    ip_end;
   logic          in_ip, in_pseudo, in_data;
   logic [15:0]   len_now;
   logic [15:0]   t0, t1, t2, t3;
   logic [15:0]   w0, w1;
   logic [18:0]   udp_total;
   logic [16:0]   ip_total;

   logic [17:0]   count;
   logic [17:0]   udp_end;
   logic          ip_ok, shrt;
   logic [15:0]   udc;
   udpck_pkg::result_type res;

   udpck_pkg::result_type q_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    cnt_ff;
   logic          push, pop;

   assign req_tready = (cnt_ff != 2'd2);
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign placed     = pos_ff[0] ? {8'd0, b} : {b, 8'd0};

   always_comb begin
      hwords_in = hwords_ff;
      if (pos_ff == udpck_pkg::IP_START) begin
         hwords_in = b[3:0];
      end
      hlen   = {hwords_in, 2'b00};
      ip_end = 7'(udpck_pkg::IP_START) + {1'b0, hlen};

      in_ip = (pos_ff >= udpck_pkg::IP_START) && (pos_ff < PW'(ip_end))
              && (pos_ff != udpck_pkg::IP_CHECK_HI) && (pos_ff != udpck_pkg::IP_CHECK_LO);
      ip_total  = {1'b0, ip_sum_ff} + (in_ip ? {1'b0, placed} : 17'd0);
      ip_sum_in = udpck_pkg::oc_fold({2'b00, ip_total});

      in_pseudo = (pos_ff == udpck_pkg::PROTO_POS)
                  || ((pos_ff >= udpck_pkg::ADDR_FIRST) && (pos_ff <= udpck_pkg::ADDR_LAST));
      in_data   = (pos_ff > udpck_pkg::ULEN_LO_POS)
                  && ((pos_ff - udpck_pkg::UDP_START) < {1'b0, ulen_ff})
                  && (pos_ff != udpck_pkg::UDP_CHK_HI) && (pos_ff != udpck_pkg::UDP_CHK_LO);

      len_now = {held_ff, b};
      w0      = {head_ff[0], head_ff[1]};
      w1      = {head_ff[2], head_ff[3]};
      t0 = 16'd0;
      t1 = 16'd0;
      t2 = 16'd0;
      t3 = 16'd0;
      ulen_in = ulen_ff;
      held_in = held_ff;
      priority if (pos_ff == udpck_pkg::ULEN_LO_POS) begin
         ulen_in = len_now;
         t0 = len_now;
         if (len_now >= 16'd2) begin
            t1 = w0;
         end else if (len_now == 16'd1) begin
            t1 = {head_ff[0], 8'd0};
         end
         if (len_now >= 16'd4) begin
            t2 = w1;
         end else if (len_now == 16'd3) begin
            t2 = {head_ff[2], 8'd0};
         end
         if (len_now >= 16'd6) begin
            t3 = len_now;
         end else if (len_now == 16'd5) begin
            t3 = {held_ff, 8'd0};
         end
      end else if (pos_ff == udpck_pkg::ULEN_HI_POS) begin
         held_in = b;
      end else if (in_pseudo || in_data) begin
         t0 = placed;
      end else begin
         t0 = 16'd0;
      end
      udp_total = {3'd0, udp_sum_ff} + {3'd0, t0} + {3'd0, t1}
                  + {3'd0, t2} + {3'd0, t3};
      udp_sum_in = udpck_pkg::oc_fold(udp_total);

      pos_in = (pos_ff != udpck_pkg::POS_MAX) ? pos_ff + PW'(1) : pos_ff;
   end

   always_comb begin
      count   = {1'b0, pos_ff} + 18'd1;
      udp_end = 18'(udpck_pkg::UDP_START) + {2'b00, ulen_in};
      ip_ok   = (count > 18'(udpck_pkg::IP_START)) && (count >= {11'd0, ip_end});
      shrt    = (count <= 18'(udpck_pkg::ULEN_LO_POS)) || !ip_ok || (count < udp_end);
      udc     = ~udp_sum_in;
      if (udc == 16'd0) begin
         udc = udpck_pkg::ALL_ONES;
      end
      res.ip_checksum  = ip_ok ? ~ip_sum_in : 16'd0;
      res.udp_checksum = shrt ? 16'd0 : udc;
      res.short_frame  = shrt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         hwords_ff  <= '0;
         ulen_ff    <= '0;
         ip_sum_ff  <= '0;
         udp_sum_ff <= '0;
      end else if (accept) begin
         if (req_tlast) begin
            pos_ff     <= '0;
            hwords_ff  <= '0;
            ulen_ff    <= '0;
            ip_sum_ff  <= '0;
            udp_sum_ff <= '0;
         end else begin
            pos_ff     <= pos_in;
            hwords_ff  <= hwords_in;
            ulen_ff    <= ulen_in;
            ip_sum_ff  <= ip_sum_in;
            udp_sum_ff <= udp_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
         if ((pos_ff >= udpck_pkg::UDP_START) && (pos_ff < udpck_pkg::ULEN_HI_POS)) begin
            head_ff[pos_ff[1:0] ^ 2'b10] <= b;
         end
      end
   end

   // output queue
   assign push       = accept && req_tlast;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {q_ff[rd_ptr_ff].udp_checksum, q_ff[rd_ptr_ff].ip_checksum};
   assign rsp_tuser  = q_ff[rd_ptr_ff].short_frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         unique case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

`default_nettype wire
